// ===== src/nccp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the nearest-center pixel colorer.
// Holds the microcode ROM (control word per step); no dependencies.
package nccp_pkg;

	localparam int DEF_MAX_CENTERS = 256;
	localparam int DEF_MAX_SIDE    = 4096;

	localparam int POS_W     = 24;   // linear pixel index
	localparam int CHAN_W    = 8;    // one color channel
	localparam int RGB_W     = 3 * CHAN_W;
	localparam int SLOT_W    = 8;
	localparam int SIDE_W    = 13;   // image_side register
	localparam int CNT_W     = 9;    // center_count register
	localparam int COL_W     = SIDE_W;  // remainder is below the side
	localparam int DR_SQ_W   = 2 * POS_W;
	localparam int DC_SQ_W   = 2 * COL_W;
	localparam int DIST_W    = DR_SQ_W + 1;
	localparam int DIV_STEPS = POS_W;   // one quotient bit per cycle
	localparam int DIV_CNT_W = 5;

	localparam logic [SIDE_W-1:0] RST_SIDE  = 13'd256;
	localparam logic [CNT_W-1:0]  RST_COUNT = 9'd1;

	typedef enum logic [0:0] {
		OP_LOAD     = 1'b0,
		OP_CLASSIFY = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		CFG_IMAGE_SIDE   = 1'b0,
		CFG_CENTER_COUNT = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_DIV,
		ST_LD_WAIT,
		ST_LD_WR,
		ST_CL_DIV,
		ST_CL_WAIT,
		ST_CL_SCAN,
		ST_CL_DR1,
		ST_CL_DR2,
		ST_CL_DR3,
		ST_CL_DR4,
		ST_RS_RD,
		ST_RS_DIV,
		ST_RS_WAIT,
		ST_RS_WR
	} step_t;

	// jump condition: when true go to tgt, else to nxt
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_DIV,       // divider still has more than one bit to go
		COND_SCAN,      // more centers to scan
		COND_SWEEP,     // more table slots to re-split
		COND_DISPATCH   // idle: pick an entry point
	} cond_t;

	typedef enum logic [1:0] {
		DIV_NONE,
		DIV_FROM_INPUT,
		DIV_FROM_TABLE
	} div_src_t;

	typedef struct packed {
		cond_t    cond;
		step_t    tgt;
		step_t    nxt;
		div_src_t div_src;
		logic     idx_clr;
		logic     idx_inc;
		logic     scan;
		logic     ld_wr;
		logic     rs_wr;
		logic     emit;
	} cw_t;

	function automatic cw_t ucode(input step_t s);
		cw_t w;
		w = '0;
		w.cond    = COND_NEVER;
		w.tgt     = ST_IDLE;
		w.nxt     = ST_IDLE;
		w.div_src = DIV_NONE;
		case (s)
			ST_IDLE: begin
				w.cond    = COND_DISPATCH;
				w.idx_clr = 1'b1;
			end
			ST_LD_DIV: begin
				w.div_src = DIV_FROM_INPUT;
				w.nxt     = ST_LD_WAIT;
			end
			ST_LD_WAIT: begin
				w.cond = COND_DIV;
				w.tgt  = ST_LD_WAIT;
				w.nxt  = ST_LD_WR;
			end
			ST_LD_WR: begin
				w.ld_wr = 1'b1;
			end
			ST_CL_DIV: begin
				w.div_src = DIV_FROM_INPUT;
				w.nxt     = ST_CL_WAIT;
			end
			ST_CL_WAIT: begin
				w.cond = COND_DIV;
				w.tgt  = ST_CL_WAIT;
				w.nxt  = ST_CL_SCAN;
			end
			ST_CL_SCAN: begin
				w.cond    = COND_SCAN;
				w.tgt     = ST_CL_SCAN;
				w.nxt     = ST_CL_DR1;
				w.scan    = 1'b1;
				w.idx_inc = 1'b1;
			end
			ST_CL_DR1: w.nxt = ST_CL_DR2;
			ST_CL_DR2: w.nxt = ST_CL_DR3;
			ST_CL_DR3: w.nxt = ST_CL_DR4;
			ST_CL_DR4: begin
				w.emit = 1'b1;
			end
			ST_RS_RD: w.nxt = ST_RS_DIV;
			ST_RS_DIV: begin
				w.div_src = DIV_FROM_TABLE;
				w.nxt     = ST_RS_WAIT;
			end
			ST_RS_WAIT: begin
				w.cond = COND_DIV;
				w.tgt  = ST_RS_WAIT;
				w.nxt  = ST_RS_WR;
			end
			ST_RS_WR: begin
				w.cond    = COND_SWEEP;
				w.tgt     = ST_RS_RD;
				w.rs_wr   = 1'b1;
				w.idx_inc = 1'b1;
			end
			default: begin
				w.cond = COND_NEVER;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== src/nearest_center_pixel_color.sv =====
`timescale 1ns / 1ps
// Nearest-center (Voronoi) pixel colorer: center table, serial divider,
// distance pipeline, all driven by a microcoded sequencer. Uses nccp_pkg.
//
// Channel     | Handshake                  | Beat contents
// ------------+----------------------------+-----------------------------------
// item in     | start & !busy              | operation, slot, position, rgb_in
// config      | cfg_valid & cfg_ready      | cfg_index, cfg_data
// result out  | result_valid (1-cycle)     | rgb_out, nearest_position, is_center
//
// Steps: a load runs a divider setup, the divider, then the table write.
// A classify gives its result after a setup step, the divider for
// row/column, a scan of one center per cycle from the table read port
// and the four pipeline drain steps; busy drops in the result cycle.
// Writing image_side starts a re-split sweep of the whole table, one
// slot at a time over MAX_CENTERS slots; busy and !cfg_ready meanwhile.
// Reset clears control and loads image_side 256, center_count 1; the table
// is undefined until loaded. Results cannot be stalled by the receiver.
module nearest_center_pixel_color #(
	parameter int MAX_CENTERS = nccp_pkg::DEF_MAX_CENTERS,
	parameter int MAX_SIDE    = nccp_pkg::DEF_MAX_SIDE
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// item channel
	input  logic                        start,
	output logic                        busy,
	input  logic                        operation,
	input  logic [nccp_pkg::SLOT_W-1:0] slot,
	input  logic [nccp_pkg::POS_W-1:0]  position,
	input  logic [nccp_pkg::CHAN_W-1:0] red_in,
	input  logic [nccp_pkg::CHAN_W-1:0] green_in,
	input  logic [nccp_pkg::CHAN_W-1:0] blue_in,
	// config channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [0:0]                  cfg_index,
	input  logic [nccp_pkg::SIDE_W-1:0] cfg_data,
	// result channel
	output logic                        result_valid,
	output logic [nccp_pkg::CHAN_W-1:0] red_out,
	output logic [nccp_pkg::CHAN_W-1:0] green_out,
	output logic [nccp_pkg::CHAN_W-1:0] blue_out,
	output logic [nccp_pkg::POS_W-1:0]  nearest_position,
	output logic                        is_center
);
	import nccp_pkg::*;

	localparam int IDX_W    = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
	localparam int CMP_W    = IDX_W + CNT_W;
	// largest side the 13-bit register can express after saturation
	localparam int SIDE_CAP = (MAX_SIDE < 8191) ? MAX_SIDE : 8191;
	localparam int CNT_CAP  = (MAX_CENTERS < 511) ? MAX_CENTERS : 511;
	localparam logic [SIDE_W-1:0] SIDE_LIM = SIDE_CAP[SIDE_W-1:0];
	localparam logic [CNT_W-1:0]  CNT_LIM  = CNT_CAP[CNT_W-1:0];
	localparam logic [IDX_W-1:0]  IDX_END  = IDX_W'(MAX_CENTERS - 1);

	// ---------------- sequencer ----------------
	step_t step_q, step_nxt;
	cw_t   cw;
	logic  pend_q;       // table must be re-split for a new side
	logic  accept;
	logic  idx_last, sweep_last;

	// ---------------- config ----------------
	logic [SIDE_W-1:0] image_side_q, side_eff;
	logic [CNT_W-1:0]  center_count_q, count_eff;
	logic              cfg_fire;

	// ---------------- item capture ----------------
	logic [SLOT_W-1:0] slot_q;
	logic [POS_W-1:0]  pos_q;
	logic [RGB_W-1:0]  rgb_q;
	logic              slot_ok;

	// ---------------- divider ----------------
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [COL_W-1:0]     div_rem_q;
	logic [POS_W-1:0]     div_quo_q;
	logic [COL_W:0]       div_trial;
	logic                 div_ge;

	// ---------------- table ----------------
	logic [POS_W-1:0] pos_mem   [MAX_CENTERS];
	logic [RGB_W-1:0] color_mem [MAX_CENTERS];
	logic [POS_W-1:0] row_mem   [MAX_CENTERS];
	logic [COL_W-1:0] col_mem   [MAX_CENTERS];
	logic [IDX_W-1:0] idx_q, slot_idx, split_waddr;
	logic             split_we;
	logic [POS_W-1:0] split_row;

	// ---------------- distance pipeline ----------------
	logic               v_s1, v_s2, v_s3, v_s4;
	logic               first_s1, first_s2, first_s3, first_s4;
	logic [POS_W-1:0]   pos_s1, pos_s2, pos_s3, pos_s4;
	logic [RGB_W-1:0]   rgb_s1, rgb_s2, rgb_s3, rgb_s4;
	logic [POS_W-1:0]   row_s1, dr_s2;
	logic [COL_W-1:0]   col_s1, dc_s2;
	logic               hit_s2, hit_s3, hit_s4;
	logic [DR_SQ_W-1:0] dr2_s3;
	logic [DC_SQ_W-1:0] dc2_s3;
	logic [DIST_W-1:0]  dist_s4;

	// ---------------- best so far / result ----------------
	logic [DIST_W-1:0] best_d_q;
	logic [POS_W-1:0]  best_pos_q;
	logic [RGB_W-1:0]  best_rgb_q;
	logic              hit_q;
	logic              res_v_q;

	// ======================================================================
	// Handshakes
	// ======================================================================
	assign busy      = (step_q != ST_IDLE) || pend_q;
	assign accept    = start && !busy;
	assign cfg_ready = !busy;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// Saturate config to what the hardware supports; side 0 acts as 1.
	always_comb begin
		if (image_side_q == '0)
			side_eff = SIDE_W'(1);
		else if (image_side_q > SIDE_LIM)
			side_eff = SIDE_LIM;
		else
			side_eff = image_side_q;
		count_eff = (center_count_q > CNT_LIM) ? CNT_LIM : center_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_side_q   <= RST_SIDE;
			center_count_q <= RST_COUNT;
		end else if (cfg_fire) begin
			case (cfg_index)
				CFG_IMAGE_SIDE:   image_side_q   <= cfg_data;
				CFG_CENTER_COUNT: center_count_q <= cfg_data[CNT_W-1:0];
				default:          ;
			endcase
		end
	end

	// Item fields held for the whole job.
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= slot;
			pos_q  <= position;
			rgb_q  <= {red_in, green_in, blue_in};
		end
	end

	assign slot_ok  = 32'(slot_q) < 32'(MAX_CENTERS);
	assign slot_idx = IDX_W'(slot_q);

	// ======================================================================
	// Microcoded sequencer: ROM decode, then next-step selection
	// ======================================================================
	always_comb begin
		cw = ucode(step_q);
	end

	assign idx_last   = (CMP_W'(idx_q) + CMP_W'(1)) == CMP_W'(count_eff);
	assign sweep_last = idx_q == IDX_END;

	always_comb begin
		step_nxt = cw.nxt;
		case (cw.cond)
			COND_NEVER: step_nxt = cw.nxt;
			COND_DIV:   step_nxt = (div_cnt_q > DIV_CNT_W'(1)) ? cw.tgt : cw.nxt;
			COND_SCAN:  step_nxt = idx_last ? cw.nxt : cw.tgt;
			COND_SWEEP: step_nxt = sweep_last ? cw.nxt : cw.tgt;
			COND_DISPATCH: begin
				if (pend_q)
					step_nxt = ST_RS_RD;
				else if (accept && (operation == OP_LOAD))
					step_nxt = ST_LD_DIV;
				else if (accept && (count_eff != '0))
					step_nxt = ST_CL_DIV;
				else
					step_nxt = ST_IDLE;   // idle, or classify with no centers
			end
			default: step_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_IDLE;
			pend_q  <= 1'b0;
			idx_q   <= '0;
			res_v_q <= 1'b0;
		end else begin
			step_q  <= step_nxt;
			res_v_q <= cw.emit;
			if (cfg_fire && (cfg_index == CFG_IMAGE_SIDE))
				pend_q <= 1'b1;
			else if (cw.rs_wr && sweep_last)
				pend_q <= 1'b0;
			if (cw.idx_clr)
				idx_q <= '0;
			else if (cw.idx_inc)
				idx_q <= idx_q + IDX_W'(1);
		end
	end

	// ======================================================================
	// Restoring divider: position -> row (quotient), column (remainder)
	// ======================================================================
	assign div_trial = {div_rem_q, div_quo_q[POS_W-1]};
	assign div_ge    = div_trial >= {1'b0, side_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cw.div_src != DIV_NONE) begin
			div_cnt_q <= DIV_CNT_W'(DIV_STEPS);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (cw.div_src)
			DIV_FROM_INPUT: begin
				div_rem_q <= '0;
				div_quo_q <= pos_q;
			end
			DIV_FROM_TABLE: begin
				div_rem_q <= '0;
				div_quo_q <= pos_s1;
			end
			default: begin
				if (div_cnt_q != '0) begin
					div_rem_q <= div_ge ? COL_W'(div_trial - {1'b0, side_eff})
					                    : div_trial[COL_W-1:0];
					div_quo_q <= {div_quo_q[POS_W-2:0], div_ge};
				end
			end
		endcase
	end

	// ======================================================================
	// Center table. One read address (idx_q) for scan and sweep.
	// ======================================================================
	assign split_we    = (cw.ld_wr && slot_ok) || cw.rs_wr;
	assign split_waddr = cw.rs_wr ? idx_q : slot_idx;
	assign split_row   = div_quo_q;

	always_ff @(posedge clk) begin
		if (cw.ld_wr && slot_ok) begin
			pos_mem[slot_idx]   <= pos_q;
			color_mem[slot_idx] <= rgb_q;
		end
		pos_s1 <= pos_mem[idx_q];
		rgb_s1 <= color_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (split_we) begin
			row_mem[split_waddr] <= split_row;
			col_mem[split_waddr] <= div_rem_q;
		end
		row_s1 <= row_mem[idx_q];
		col_s1 <= col_mem[idx_q];
	end

	// ======================================================================
	// Distance pipeline: read -> |diff| -> square -> sum -> compare
	// Pixel row/column stay in the divider registers during the scan.
	// ======================================================================
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cw.scan;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= idx_q == '0;
		// stage 2
		first_s2 <= first_s1;
		pos_s2   <= pos_s1;
		rgb_s2   <= rgb_s1;
		dr_s2    <= (row_s1 > div_quo_q) ? row_s1 - div_quo_q : div_quo_q - row_s1;
		dc_s2    <= (col_s1 > div_rem_q) ? col_s1 - div_rem_q : div_rem_q - col_s1;
		hit_s2   <= pos_s1 == pos_q;
		// stage 3
		first_s3 <= first_s2;
		pos_s3   <= pos_s2;
		rgb_s3   <= rgb_s2;
		hit_s3   <= hit_s2;
		dr2_s3   <= dr_s2 * dr_s2;
		dc2_s3   <= dc_s2 * dc_s2;
		// stage 4
		first_s4 <= first_s3;
		pos_s4   <= pos_s3;
		rgb_s4   <= rgb_s3;
		hit_s4   <= hit_s3;
		dist_s4  <= DIST_W'(dr2_s3) + DIST_W'(dc2_s3);
	end

	// Strict less-than keeps the earlier slot on a tie.
	always_ff @(posedge clk) begin
		if (v_s4 && (first_s4 || (dist_s4 < best_d_q))) begin
			best_d_q   <= dist_s4;
			best_pos_q <= pos_s4;
			best_rgb_q <= rgb_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hit_q <= 1'b0;
		else if (cw.idx_clr)
			hit_q <= 1'b0;
		else if (v_s4 && hit_s4)
			hit_q <= 1'b1;
	end

	// ======================================================================
	// Result beat
	// ======================================================================
	assign result_valid     = res_v_q;
	assign red_out          = best_rgb_q[3*CHAN_W-1:2*CHAN_W];
	assign green_out        = best_rgb_q[2*CHAN_W-1:CHAN_W];
	assign blue_out         = best_rgb_q[CHAN_W-1:0];
	assign nearest_position = best_pos_q;
	assign is_center        = hit_q;

`ifndef SYNTHESIS
	a_result_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_result_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(step_q) == ST_CL_DR4)
		else $error("result without a finished scan");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.div_src != DIV_NONE) |-> div_cnt_q == '0)
		else $error("divider restarted while running");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cw.scan |-> CMP_W'(idx_q) < CMP_W'(count_eff))
		else $error("scan index past center count");

	a_side_write_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_fire && (cfg_index == CFG_IMAGE_SIDE)) |=> (busy && !cfg_ready))
		else $error("side write did not start table re-split");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nearest_center_pixel_color (Voronoi pixel colorer).
// Depends on nccp_pkg and the block itself; needs nothing else to run.
module testbench;
	import nccp_pkg::*;

	localparam int TABLE_DEPTH   = DEF_MAX_CENTERS;
	localparam int SIDE_CAP      = DEF_MAX_SIDE;
	localparam int SETTLE_CYCLES = 320;   // longest classify scans the whole table
	localparam int ITEM_TARGET   = 2000;

	// one beat on the item channel, plus the idle cycles to leave before it
	typedef struct {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  pos;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		int unsigned       gap;
	} pixel_op_t;

	// what one classify must return
	typedef struct {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [POS_W-1:0]  pos;
		logic              hit;
	} pixel_color_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	logic              operation = 1'b0;
	logic [SLOT_W-1:0] slot      = '0;
	logic [POS_W-1:0]  position  = '0;
	logic [CHAN_W-1:0] red_in    = '0;
	logic [CHAN_W-1:0] green_in  = '0;
	logic [CHAN_W-1:0] blue_in   = '0;
	logic              cfg_valid = 1'b0;
	logic [0:0]        cfg_index = '0;
	logic [SIDE_W-1:0] cfg_data  = '0;
	logic              busy;
	logic              cfg_ready;
	logic              result_valid;
	logic [CHAN_W-1:0] red_out;
	logic [CHAN_W-1:0] green_out;
	logic [CHAN_W-1:0] blue_out;
	logic [POS_W-1:0]  nearest_position;
	logic              is_center;

	nearest_center_pixel_color DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.operation        (operation),
		.slot             (slot),
		.position         (position),
		.red_in           (red_in),
		.green_in         (green_in),
		.blue_in          (blue_in),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.result_valid     (result_valid),
		.red_out          (red_out),
		.green_out        (green_out),
		.blue_out         (blue_out),
		.nearest_position (nearest_position),
		.is_center        (is_center)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: center table and register copies, updated only on
	// accepted beats (items in the driver, writes in write_reg).
	// ------------------------------------------------------------------
	logic [POS_W-1:0]  center_pos_tbl [TABLE_DEPTH];
	logic [RGB_W-1:0]  center_rgb_tbl [TABLE_DEPTH];
	logic [SIDE_W-1:0] side_reg  = RST_SIDE;
	logic [CNT_W-1:0]  count_reg = RST_COUNT;

	pixel_op_t    queued_ops[$];        // filled by stimulus, drained by driver
	pixel_color_t expected_colors[$];   // one per accepted classify that answers, oldest first
	int unsigned  ops_queued   = 0;
	int unsigned  ops_accepted = 0;
	int unsigned  fail_count   = 0;

	// Stimulus-side view: what has been loaded so far, so a classify never
	// scans a slot that was never written.
	bit               gen_loaded [TABLE_DEPTH];
	logic [POS_W-1:0] gen_pos [TABLE_DEPTH] = '{default: '0};
	int unsigned      gen_side  = RST_SIDE;
	int unsigned      gen_count = RST_COUNT;

	// register value -> value actually used (zero side acts as one,
	// oversized side and count saturate)
	function automatic int unsigned clamp_side(input logic [SIDE_W-1:0] raw);
		if (raw == 0)
			return 1;
		return (raw > SIDE_CAP) ? SIDE_CAP : raw;
	endfunction

	function automatic int unsigned clamp_count(input logic [CNT_W-1:0] raw);
		return (raw > TABLE_DEPTH) ? TABLE_DEPTH : raw;
	endfunction

	// Scan the first count centers for the least squared distance; strict
	// less-than keeps the earliest slot on a tie. Zero count: no result.
	function automatic void predict_nearest(input logic [POS_W-1:0] pix);
		longint unsigned side, prow, pcol, crow, ccol, dr, dc, sq_dist, best_d;
		int unsigned     cnt, best_i;
		pixel_color_t    res;
		side   = 64'(clamp_side(side_reg));
		cnt    = clamp_count(count_reg);
		best_d = 0;
		best_i = 0;
		res.hit = 1'b0;
		if (cnt == 0)
			return;
		prow = 64'(pix) / side;
		pcol = 64'(pix) % side;
		for (int unsigned i = 0; i < cnt; i++) begin
			crow    = 64'(center_pos_tbl[i]) / side;
			ccol    = 64'(center_pos_tbl[i]) % side;
			dr      = (crow > prow) ? crow - prow : prow - crow;
			dc      = (ccol > pcol) ? ccol - pcol : pcol - ccol;
			sq_dist = dr * dr + dc * dc;
			if (center_pos_tbl[i] == pix)
				res.hit = 1'b1;
			if (i == 0 || sq_dist < best_d) begin
				best_d = sq_dist;
				best_i = i;
			end
		end
		{res.red, res.green, res.blue} = center_rgb_tbl[best_i];
		res.pos = center_pos_tbl[best_i];
		expected_colors.push_back(res);
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents queued items after their gap, holds each beat until
	// start & !busy, and feeds every accepted beat to the predictor.
	// ------------------------------------------------------------------
	pixel_op_t   on_port;
	int unsigned idle_wait = 0;

	always @(posedge clk) begin : drive_items
		logic presenting;
		presenting = start;
		if (start && !busy) begin
			if (on_port.op == OP_LOAD) begin
				center_pos_tbl[on_port.slot] = on_port.pos;
				center_rgb_tbl[on_port.slot] = {on_port.red, on_port.green, on_port.blue};
			end else begin
				predict_nearest(on_port.pos);
			end
			ops_accepted++;
			presenting = 1'b0;
		end
		// one NBA to start per edge: back-to-back beats keep it high
		if (!presenting) begin
			if (queued_ops.size() != 0 && idle_wait >= queued_ops[0].gap) begin
				on_port = queued_ops.pop_front();
				idle_wait = 0;
				operation <= on_port.op;
				slot      <= on_port.slot;
				position  <= on_port.pos;
				red_in    <= on_port.red;
				green_in  <= on_port.green;
				blue_in   <= on_port.blue;
				start     <= 1'b1;
			end else begin
				if (queued_ops.size() != 0)
					idle_wait++;
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: the strobe marks a one-cycle result; compare field by field
	// against the oldest pending pixel.
	// ------------------------------------------------------------------
	task automatic check_field(input string what, input logic [POS_W-1:0] want,
			input logic [POS_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h",
				$time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : observe_results
		pixel_color_t want;
		if (arst_n) begin
			if ($isunknown(result_valid)) begin
				fail_count++;
				$display("%0t ns: result_valid expected 0/1, actual %b",
					$time, result_valid);
			end else if (result_valid) begin
				if (expected_colors.size() == 0) begin
					fail_count++;
					$display("%0t ns: unexpected result, expected none, %s %h%h%h pos %0h",
						$time, "actual rgb", red_out, green_out, blue_out,
						nearest_position);
				end else begin
					want = expected_colors.pop_front();
					check_field("red_out", want.red, red_out);
					check_field("green_out", want.green, green_out);
					check_field("blue_out", want.blue, blue_out);
					check_field("nearest_position", want.pos, nearest_position);
					check_field("is_center", want.hit, is_center);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers. Queue access happens at the falling edge so it
	// never races the driver or the monitor.
	// ------------------------------------------------------------------

	// all queued beats accepted and every classify answered
	task automatic wait_quiet();
		while (ops_accepted != ops_queued || expected_colors.size() != 0)
			@(negedge clk);
	endtask

	task automatic load_center(input logic [SLOT_W-1:0] s, input logic [POS_W-1:0] p,
			input logic [RGB_W-1:0] rgb, input int unsigned gap);
		pixel_op_t c;
		c.op   = OP_LOAD;
		c.slot = s;
		c.pos  = p;
		{c.red, c.green, c.blue} = rgb;
		c.gap  = gap;
		gen_loaded[s] = 1'b1;
		gen_pos[s]    = p;
		queued_ops.push_back(c);
		ops_queued++;
	endtask

	// slots about to be scanned get loaded first if they never were
	task automatic classify_pixel(input logic [POS_W-1:0] p, input int unsigned gap);
		pixel_op_t c;
		for (int unsigned i = 0; i < gen_count; i++)
			if (!gen_loaded[i])
				load_center(i, $urandom_range(0, gen_side * gen_side - 1), $urandom, 0);
		c.op    = OP_CLASSIFY;
		c.slot  = $urandom;
		c.pos   = p;
		c.red   = $urandom;
		c.green = $urandom;
		c.blue  = $urandom;
		c.gap   = gap;
		queued_ops.push_back(c);
		ops_queued++;
	endtask

	// Register writes only with the block idle: drain, let a trailing load or
	// a resultless classify finish, then one beat on the config channel.
	// A side write kicks off a table sweep; the driver just sees busy.
	task automatic write_reg(input cfg_idx_t idx, input logic [SIDE_W-1:0] data);
		wait_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		if (idx == CFG_IMAGE_SIDE) begin
			side_reg = data;
			gen_side = clamp_side(data);
		end else begin
			count_reg = data[CNT_W-1:0];
			gen_count = clamp_count(data[CNT_W-1:0]);
		end
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// mostly small images (lots of ties), some large, zero and oversized
	function automatic logic [SIDE_W-1:0] pick_side();
		int unsigned k;
		k = $urandom_range(0, 19);
		if (k < 10) return $urandom_range(1, 16);
		if (k < 14) return $urandom_range(17, 300);
		if (k < 16) return SIDE_CAP;
		if (k == 16) return 0;
		if (k == 17) return $urandom_range(SIDE_CAP + 1, (1 << SIDE_W) - 1);
		return $urandom_range(1, SIDE_CAP - 1);
	endfunction

	// count lives in the low 9 bits; upper data bits are junk the block drops
	function automatic logic [SIDE_W-1:0] pick_count_word();
		logic [SIDE_W-1:0] w;
		int unsigned       k;
		w = $urandom;
		k = $urandom_range(0, 19);
		if (k < 14) w[CNT_W-1:0] = $urandom_range(1, 12);
		else if (k < 17) w[CNT_W-1:0] = $urandom_range(13, 64);
		else if (k == 17) w[CNT_W-1:0] = 0;
		else if (k == 18) w[CNT_W-1:0] = $urandom_range(TABLE_DEPTH, (1 << CNT_W) - 1);
		else w[CNT_W-1:0] = $urandom_range(65, TABLE_DEPTH - 1);
		return w;
	endfunction

	// center positions: mostly inside the image, some anywhere, some copies
	// of another slot so two centers sit on the same pixel
	function automatic logic [POS_W-1:0] pick_center_pos();
		int unsigned k, other;
		k     = $urandom_range(0, 19);
		other = $urandom_range(0, TABLE_DEPTH - 1);
		if (k >= 15 && gen_loaded[other]) return gen_pos[other];
		if (k >= 12 && k < 15) return $urandom;
		return $urandom_range(0, gen_side * gen_side - 1);
	endfunction

	// pixels: on a scanned center, just beside one, inside or past the image
	function automatic logic [POS_W-1:0] pick_pixel();
		int unsigned k;
		k = $urandom_range(0, 19);
		if (k < 8 && gen_count > 0)
			return gen_pos[$urandom_range(0, gen_count - 1)];
		if (k < 10 && gen_count > 0)
			return gen_pos[$urandom_range(0, gen_count - 1)] + $urandom_range(0, 2 * gen_side)
				- gen_side;
		if (k < 17) return $urandom_range(0, gen_side * gen_side - 1);
		return $urandom;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_gap(input bit burst);
		int unsigned k;
		if (burst)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 70) return 0;
		if (k < 90) return $urandom_range(1, 4);
		if (k < 98) return $urandom_range(5, 40);
		return $urandom_range(50, 300);
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : run_test
		int unsigned  phase, n_items;
		bit           burst;
		logic [SLOT_W-1:0] s;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset registers (side 256, one center), extreme slots and
		// positions, pixel on a center, pixel far past the image
		load_center(0, 24'h000101, 24'hFF00AA, 0);
		load_center(TABLE_DEPTH - 1, 24'hFFFFFF, 24'h00FF55, 0);
		classify_pixel(24'h000101, 0);
		classify_pixel(24'h000000, 3);
		classify_pixel(24'hFFFFFF, 0);

		// zero side acts as one; slot 1 duplicates slot 0, earlier slot wins
		write_reg(CFG_IMAGE_SIDE, 13'd0);
		write_reg(CFG_CENTER_COUNT, 13'd2);
		load_center(1, 24'h000101, 24'h123456, 0);
		classify_pixel(24'h000101, 0);
		classify_pixel(24'h800000, 0);

		// oversized side saturates; junk in the upper count bits is dropped
		write_reg(CFG_IMAGE_SIDE, 13'h1FFF);
		write_reg(CFG_CENTER_COUNT, 13'h1003);
		load_center(2, 24'hFFFFFF, 24'hABCDEF, 0);
		classify_pixel(24'hFFFFFF, 0);
		classify_pixel(24'h000FFF, 1);

		// zero count: classify is taken but answers nothing
		write_reg(CFG_CENTER_COUNT, 13'h1E00);
		classify_pixel(24'h000123, 0);
		classify_pixel(24'hFFFFFF, 0);

		// side exactly at the maximum, then a one-pixel-wide image
		write_reg(CFG_IMAGE_SIDE, SIDE_CAP);
		write_reg(CFG_CENTER_COUNT, 13'd3);
		classify_pixel(24'h7FF800, 0);
		classify_pixel(24'h000FFF, 0);
		write_reg(CFG_IMAGE_SIDE, 13'd1);
		classify_pixel(24'h000102, 0);
		classify_pixel(24'h000000, 0);

		// random phases; phase 2 forces the oversized count (full table scan)
		phase = 0;
		while (ops_queued < ITEM_TARGET) begin
			if (phase == 0 || $urandom_range(0, 1))
				write_reg(CFG_IMAGE_SIDE, pick_side());
			write_reg(CFG_CENTER_COUNT, (phase == 2) ? 13'h1FFF : pick_count_word());
			burst   = ($urandom_range(0, 3) == 0);
			n_items = (gen_count > 64) ? 15 : $urandom_range(40, 120);
			repeat (n_items) begin
				// now and then hold off until the block has answered everything
				if ($urandom_range(0, 19) == 0)
					wait_quiet();
				if ($urandom_range(0, 9) < 3) begin
					s = (gen_count > 0 && $urandom_range(0, 9) < 6) ?
						$urandom_range(0, gen_count - 1) : $urandom;
					load_center(s, pick_center_pos(), $urandom, pick_gap(burst));
				end else begin
					classify_pixel(pick_pixel(), pick_gap(burst));
				end
			end
			phase++;
		end

		wait_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// hard stop: several times the slowest legal run
	initial begin : watchdog
		#200_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
